// File: rtl/satq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// satq_pkg
// Types and fixed constants shared by the sorted alarm timer queue.
// ----------------------------------------------------------------------------
package satq_pkg;

    localparam int ID_W          = 16;
    localparam int DELAY_W       = 16;
    localparam int STATUS_W      = 2;
    localparam int IN_TDATA_W    = 32;   // delay, id
    localparam int OUT_DATA_BITS = 34;   // status, id, delay
    localparam int OUT_TDATA_W   = 40;
    localparam int MAX_RESULTS   = 16;   // expired alarms sent per tick at most
    localparam int K_W           = 5;

    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_SET      = 1'b1;
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_EXPIRED = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REPLACED = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DEL_RD,
        S_DEL_WR,
        S_INS_RD,
        S_INS_CMP,
        S_SHUP_RD,
        S_SHUP_WR,
        S_ACK,
        S_TK_CHK,
        S_TK_PEEK,
        S_TK_EMIT
    } t_state;

endpackage
`default_nettype wire

// File: rtl/sorted_alarm_timer_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted alarm timer queue. One transaction in flight; s_axis_tready is high only when idle.
// Set: an id search over the held alarms (with the removal shift on a replace), then, unless
//   the queue is full, a position search plus insert shift, then the ack.
// Tick: back to idle when nothing expires, else each expired alarm is emitted, then removed.
// All slot traffic goes through the single-port-pair slot memory and one shared adder.
// Synchronous active-low reset clears the alarm count, time and output valid.
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue_unit
// Alarms held in expiry order in a slot memory, walked by a small sequencer.
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue_unit #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire [satq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // delay_seconds, message_id
    input  wire                                s_axis_tuser,   // cmd
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [satq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // status, out_id, out_delay
    output logic                               m_axis_tuser,   // kind
    output logic                               m_axis_tlast    // last
);
    import satq_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = TIME_WIDTH + ID_W + DELAY_W;

    t_state r_state, n_state;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_j;
    logic [TIME_WIDTH-1:0] r_now;
    logic [TIME_WIDTH-1:0] r_exp;
    logic [ID_W-1:0]       r_id;
    logic [DELAY_W-1:0]    r_delay;
    t_status               r_status;
    logic                  r_tick;
    logic                  r_last;
    logic [K_W-1:0]        r_k;

    logic                  r_out_valid;
    logic                  r_out_kind;
    t_status               r_out_status;
    logic [ID_W-1:0]       r_out_id;
    logic [DELAY_W-1:0]    r_out_delay;
    logic                  r_out_last;

    logic [SW-1:0]         rd_word;
    logic [TIME_WIDTH-1:0] rd_exp;
    logic [ID_W-1:0]       rd_id;
    logic [DELAY_W-1:0]    rd_delay;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [SW-1:0]         mem_wdata;
    logic [AW-1:0]         mem_raddr;

    t_alu_op               alu_op;
    logic [TIME_WIDTH-1:0] alu_a;
    logic [TIME_WIDTH-1:0] alu_b;
    logic [TIME_WIDTH-1:0] alu_y;
    logic                  alu_neg;

    logic                  in_acc;
    logic                  out_free;
    logic                  out_load;
    logic [CW-1:0]         idx_inc;
    logic                  del_done;
    logic                  peek_last;
    logic [DELAY_W-1:0]    in_delay;
    logic [ID_W-1:0]       in_id;

    assign in_delay = s_axis_tdata[DELAY_W-1:0];
    assign in_id    = s_axis_tdata[DELAY_W +: ID_W];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign idx_inc  = r_idx + CW'(1);
    assign del_done = (idx_inc >= r_count);

    assign rd_exp   = rd_word[TIME_WIDTH-1:0];
    assign rd_id    = rd_word[TIME_WIDTH +: ID_W];
    assign rd_delay = rd_word[TIME_WIDTH + ID_W +: DELAY_W];

    // this alarm is the last of the tick if the budget runs out, nothing follows,
    // or the next slot has not expired yet
    assign peek_last = (r_k == K_W'(MAX_RESULTS - 1)) || (r_count == CW'(1)) || alu_neg;

    satq_store #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (SW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_word)
    );

    satq_alu #(
        .WIDTH (TIME_WIDTH)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_y   (alu_y),
        .o_neg (alu_neg)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (s_axis_tuser == CMD_SET) ? S_SRCH_RD : S_TK_CHK;
                end
            end
            S_SRCH_RD: begin
                if (r_idx == r_count) begin
                    n_state = (r_count == CW'(TABLE_DEPTH)) ? S_ACK : S_INS_RD;
                end else begin
                    n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                n_state = (rd_id == r_id) ? S_DEL_RD : S_SRCH_RD;
            end
            S_DEL_RD: begin
                if (del_done) begin
                    if (!r_tick) begin
                        n_state = S_INS_RD;
                    end else begin
                        n_state = r_last ? S_IDLE : S_TK_CHK;
                    end
                end else begin
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR:   n_state = S_DEL_RD;
            S_INS_RD:   n_state = (r_idx == r_count) ? S_SHUP_RD : S_INS_CMP;
            S_INS_CMP:  n_state = alu_neg ? S_INS_RD : S_SHUP_RD;
            S_SHUP_RD:  n_state = (r_j == r_idx) ? S_ACK : S_SHUP_WR;
            S_SHUP_WR:  n_state = S_SHUP_RD;
            S_ACK:      n_state = out_free ? S_IDLE : S_ACK;
            S_TK_CHK: begin
                n_state = ((r_count == '0) || alu_neg) ? S_IDLE : S_TK_PEEK;
            end
            S_TK_PEEK:  n_state = S_TK_EMIT;
            S_TK_EMIT:  n_state = out_free ? S_DEL_RD : S_TK_EMIT;
            default:    n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: memory port, shared adder, output load
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = rd_word;
        mem_raddr = '0;
        alu_op    = ALU_SUB;
        alu_a     = r_now;
        alu_b     = rd_exp;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                alu_op = ALU_ADD;
                alu_b  = (s_axis_tuser == CMD_SET) ? TIME_WIDTH'(in_delay)
                                                   : TIME_WIDTH'(1);
            end
            S_SRCH_RD: mem_raddr = r_idx[AW-1:0];
            S_DEL_RD:  mem_raddr = del_done ? '0 : idx_inc[AW-1:0];
            S_DEL_WR:  mem_we = 1'b1;
            S_INS_RD:  mem_raddr = r_idx[AW-1:0];
            S_INS_CMP: begin
                alu_a = rd_exp;
                alu_b = r_exp;
            end
            S_SHUP_RD: begin
                if (r_j == r_idx) begin
                    mem_we    = 1'b1;
                    mem_wdata = {r_delay, r_id, r_exp};
                end else begin
                    mem_raddr = r_j[AW-1:0] - AW'(1);
                end
            end
            S_SHUP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_j[AW-1:0];
            end
            S_ACK:     out_load = out_free;
            S_TK_CHK:  mem_raddr = AW'(1);
            S_TK_EMIT: out_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_now   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx    <= '0;
                        r_k      <= '0;
                        r_status <= ST_INSERTED;
                        r_last   <= 1'b0;
                        if (s_axis_tuser == CMD_SET) begin
                            r_tick  <= 1'b0;
                            r_exp   <= alu_y;
                            r_id    <= in_id;
                            r_delay <= in_delay;
                        end else begin
                            r_tick <= 1'b1;
                            r_now  <= alu_y;
                        end
                    end
                end
                S_SRCH_RD: begin
                    if (r_idx == r_count) begin
                        r_idx <= '0;
                        if (r_count == CW'(TABLE_DEPTH)) begin
                            r_status <= ST_FULL;
                        end
                    end
                end
                S_SRCH_CMP: begin
                    if (rd_id == r_id) begin
                        r_status <= ST_REPLACED;
                    end else begin
                        r_idx <= idx_inc;
                    end
                end
                S_DEL_RD: begin
                    if (del_done) begin
                        r_count <= r_count - CW'(1);
                        r_idx   <= '0;
                    end
                end
                S_DEL_WR:  r_idx <= idx_inc;
                S_INS_RD: begin
                    if (r_idx == r_count) begin
                        r_j <= r_count;
                    end
                end
                S_INS_CMP: begin
                    if (alu_neg) begin
                        r_idx <= idx_inc;
                    end else begin
                        r_j <= r_count;
                    end
                end
                S_SHUP_RD: begin
                    if (r_j == r_idx) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                S_SHUP_WR: r_j <= r_j - CW'(1);
                S_TK_CHK: begin
                    r_id    <= rd_id;
                    r_delay <= rd_delay;
                end
                S_TK_PEEK: r_last <= peek_last;
                S_TK_EMIT: begin
                    if (out_free) begin
                        r_k   <= r_k + K_W'(1);
                        r_idx <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_id    <= r_id;
            r_out_delay <= r_delay;
            if (r_state == S_ACK) begin
                r_out_kind   <= KIND_ACK;
                r_out_status <= r_status;
                r_out_last   <= 1'b1;
            end else begin
                r_out_kind   <= KIND_EXPIRED;
                r_out_status <= ST_INSERTED;
                r_out_last   <= r_last;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_DATA_BITS){1'b0}},
                            r_out_delay, r_out_id, r_out_status};

endmodule
`default_nettype wire

// File: rtl/satq_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// satq_alu
// Shared time adder/subtractor. o_neg is the top result bit; when subtracting, the sign of a - b, i.e. a before b.
// ----------------------------------------------------------------------------
module satq_alu #(
    parameter int WIDTH = 32
) (
    input  var satq_pkg::t_alu_op i_op,
    input  wire [WIDTH-1:0]       i_a,
    input  wire [WIDTH-1:0]       i_b,
    output logic [WIDTH-1:0]      o_y,
    output logic                  o_neg
);
    import satq_pkg::*;

    always_comb begin
        case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end

    assign o_neg = o_y[WIDTH-1];

endmodule
`default_nettype wire

// File: rtl/satq_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// satq_store
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module satq_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import satq_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/satq_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// satq_chk
// Port-level checks for the sorted alarm timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module satq_chk (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [satq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input wire                              m_axis_tuser,
    input wire                              m_axis_tlast
);
    import satq_pkg::*;

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one transaction at a time: input closes right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // an ack is always the only result of its set
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_ACK) |-> m_axis_tlast)
        else $error("ack without last");

    a_exp_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_EXPIRED)
            |-> (m_axis_tdata[1:0] == ST_INSERTED))
        else $error("expired alarm with nonzero status");

endmodule

bind sorted_alarm_timer_queue_unit satq_chk u_satq_chk (.*);
`default_nettype wire
